// ===== rtl/mvsf_pkg.sv =====
// ----------------------------------------------------------------------------
// mvsf_pkg: shared types and constants of the masked volume spread fill
// Word layouts for the item and result queues, the command word between the
// front and the back, the decoded configuration, and the fixed codes.
// ----------------------------------------------------------------------------
package mvsf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int IDX_W      = 15;
    localparam int KIND_W     = 2;
    localparam int SIZE_W     = 6;
    localparam int PASS_W     = 8;
    localparam int CCOUNT_W   = 3;
    localparam int LANES_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int IN_SAMPLES = 4;
    localparam int MARK_W     = 2;
    localparam int SIZE_MAX   = 32;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_COUNT = 3'd4;

    // Voxel marks. The two front marks alternate; the next one is MARK_SUM minus the last.
    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_ONE   = 2'd1;
    localparam logic [MARK_W-1:0] MARK_SUM   = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [IDX_W-1:0]           voxel_index;
        logic                       inside_req;
        logic signed [SAMPLE_W-1:0] sample_0;
        logic signed [SAMPLE_W-1:0] sample_1;
        logic signed [SAMPLE_W-1:0] sample_2;
        logic signed [SAMPLE_W-1:0] sample_3;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value_0;
        logic signed [SAMPLE_W-1:0] value_1;
        logic signed [SAMPLE_W-1:0] value_2;
        logic signed [SAMPLE_W-1:0] value_3;
        logic                       filled;
        logic [PASS_W-1:0]          passes_done;
    } t_out_word;

    typedef struct packed {
        logic [KIND_W-1:0]                      kind;
        logic                                   in_range;
        logic [IDX_W-1:0]                       voxel_index;
        logic                                   in_stencil;
        logic [IN_SAMPLES-1:0][SAMPLE_W-1:0]    samples;
    } t_cmd;

    typedef struct packed {
        logic [SIZE_W-1:0]  size_x;
        logic [SIZE_W-1:0]  size_y;
        logic [SIZE_W-1:0]  size_z;
        logic [PASS_W-1:0]  pass_limit;
        logic [LANES_W-1:0] lanes;
    } t_cfg;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(SIZE_MAX)) begin
            r = SIZE_W'(SIZE_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/mvsf_ram.sv =====
// ----------------------------------------------------------------------------
// mvsf_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module mvsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/mvsf_front.sv =====
// ----------------------------------------------------------------------------
// mvsf_front: item intake and classification
// Accepts items, drops unknown kinds, checks the address range and queues
// commands for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module mvsf_front #(
    parameter int MAX_VOXELS = 32768
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  mvsf_pkg::t_in_word i_in_word,
    output logic               o_cmd_valid,
    output mvsf_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_pop
);
    import mvsf_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;
    logic       accept, keep;
    t_cmd       cmd;

    assign full        = (r_count == 2'd2);
    assign accept      = push && !full;
    assign keep        = accept && (i_in_word.kind != KIND_SPARE);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd.kind        = i_in_word.kind;
        cmd.in_range    = (32'(i_in_word.voxel_index) < 32'(MAX_VOXELS));
        cmd.voxel_index = i_in_word.voxel_index;
        cmd.in_stencil  = i_in_word.inside_req;
        cmd.samples     = {i_in_word.sample_3, i_in_word.sample_2,
                           i_in_word.sample_1, i_in_word.sample_0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (keep) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            r_count <= r_count + 2'(keep) - 2'(i_cmd_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_q[r_wp] <= cmd;
        end
    end

endmodule

// ===== rtl/mvsf_div.sv =====
// ----------------------------------------------------------------------------
// mvsf_div: multi-lane restoring divider by a small shared divisor
// One quotient bit per lane per cycle; all lanes share the divisor.
// ----------------------------------------------------------------------------
module mvsf_div #(
    parameter int LANES = 4,
    parameter int NUM_W = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [LANES-1:0][NUM_W-1:0] i_num,
    input  logic [3:0]                  i_den,
    output logic                        o_done,
    output logic [LANES-1:0][NUM_W-1:0] o_quot
);
    import mvsf_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [LANES-1:0][NUM_W-1:0] r_q;
    logic [4:0]                  r_rem [LANES];
    logic [3:0]                  r_den;
    logic [CW-1:0]               r_left;
    logic                        r_busy, r_done;

    logic [5:0] rem_sh [LANES];
    logic       qbit   [LANES];
    logic [4:0] rem_nx [LANES];

    always_comb begin
        for (int c = 0; c < LANES; c++) begin
            rem_sh[c] = {r_rem[c], r_q[c][NUM_W-1]};
            qbit[c]   = (rem_sh[c] >= 6'(r_den));
            rem_nx[c] = qbit[c] ? 5'(rem_sh[c] - 6'(r_den)) : rem_sh[c][4:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= CW'(NUM_W);
            end else if (r_busy) begin
                r_left <= r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            for (int c = 0; c < LANES; c++) begin
                r_rem[c] <= '0;
            end
        end else if (r_busy) begin
            for (int c = 0; c < LANES; c++) begin
                r_rem[c] <= rem_nx[c];
                r_q[c]   <= {r_q[c][NUM_W-2:0], qbit[c]};
            end
        end
    end

endmodule

// ===== rtl/mvsf_back.sv =====
// ----------------------------------------------------------------------------
// mvsf_back: command execution and result queue
// Writes loaded voxels, answers reads and sequences the spreading passes
// over the voxel and mark memories; results go out through a two-entry queue.
// ----------------------------------------------------------------------------
module mvsf_back #(
    parameter int MAX_VOXELS  = 32768,
    parameter int LANES       = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mvsf_pkg::t_cfg      i_cfg,
    input  logic                i_cmd_valid,
    input  mvsf_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                empty,
    input  logic                pop,
    output mvsf_pkg::t_out_word o_out_word
);
    import mvsf_pkg::*;

    localparam int AW    = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
    localparam int SB    = SAMPLE_W;
    localparam int DW    = LANES * SB;
    localparam int SUM_W = SB + 3;
    localparam int NUM_W = SB + 4;
    localparam int XL    = (LANES > IN_SAMPLES) ? LANES : IN_SAMPLES;
    localparam int P_W   = 16;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDW   = 4'd1;
    localparam logic [3:0] S_PASS  = 4'd2;
    localparam logic [3:0] S_VMARK = 4'd3;
    localparam logic [3:0] S_VWAIT = 4'd4;
    localparam logic [3:0] S_NB    = 4'd5;
    localparam logic [3:0] S_NBW   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DIVW  = 4'd8;
    localparam logic [3:0] S_NEXT  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    localparam logic [2:0] NB_XM  = 3'd0;
    localparam logic [2:0] NB_XP  = 3'd1;
    localparam logic [2:0] NB_YM  = 3'd2;
    localparam logic [2:0] NB_YP  = 3'd3;
    localparam logic [2:0] NB_ZM  = 3'd4;
    localparam logic [2:0] NB_ZP  = 3'd5;
    localparam logic [2:0] NB_END = 3'd6;

    logic [3:0]              r_state, n_state;
    logic [SIZE_W-1:0]       r_x, n_x, r_y, n_y, r_z, n_z;
    logic [P_W-1:0]          r_p, n_p;
    logic [10:0]             r_incz, n_incz;
    logic [MARK_W-1:0]       r_last, n_last, r_front, n_front;
    logic [PASS_W-1:0]       r_done, n_done, r_k, n_k;
    logic                    r_hit, n_hit;
    logic [2:0]              r_nb, n_nb, r_cnt, n_cnt;
    logic signed [SUM_W-1:0] r_sum [LANES];
    logic signed [SUM_W-1:0] n_sum [LANES];
    logic [DW-1:0]           r_own, n_own;
    logic                    r_rd_ok, n_rd_ok;

    t_out_word  r_oq [2];
    logic       r_owp, r_orp;
    logic [1:0] r_ocount;
    logic       push_out, pop_ok;
    t_out_word  out_word;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [DW-1:0]     wdata, rdata;
    logic [MARK_W-1:0] mark_wdata, mark_rdata;

    logic                        div_start, div_done;
    logic [LANES-1:0][NUM_W-1:0] div_num, div_quot;

    logic                        nb_ok;
    logic [P_W-1:0]              nb_addr;
    logic [XL*SB-1:0]            rd_ext;
    logic [XL*SAMPLE_W-1:0]      ld_ext;
    logic [IN_SAMPLES-1:0][SAMPLE_W-1:0] vals;
    logic [SUM_W-1:0]            mag;
    logic [NUM_W-1:0]            res;
    logic                        last_x, last_y, last_z;

    mvsf_ram #(.WIDTH(DW), .DEPTH(MAX_VOXELS)) u_voxel_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    mvsf_ram #(.WIDTH(MARK_W), .DEPTH(MAX_VOXELS)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (mark_wdata),
        .i_raddr (raddr),
        .o_rdata (mark_rdata)
    );

    mvsf_div #(.LANES(LANES), .NUM_W(NUM_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   ({r_cnt, 1'b0}),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign rd_ext = (XL*SB)'(rdata);
    assign ld_ext = (XL*SAMPLE_W)'(i_cmd.samples);
    assign last_x = !(r_x + SIZE_W'(1) < i_cfg.size_x);
    assign last_y = !(r_y + SIZE_W'(1) < i_cfg.size_y);
    assign last_z = !(r_z + SIZE_W'(1) < i_cfg.size_z);

    // Neighbor address for the current neighbor slot.
    always_comb begin
        nb_ok   = 1'b0;
        nb_addr = r_p;
        case (r_nb)
            NB_XM: begin
                nb_ok   = (r_x != '0);
                nb_addr = r_p - P_W'(1);
            end
            NB_XP: begin
                nb_ok   = !last_x;
                nb_addr = r_p + P_W'(1);
            end
            NB_YM: begin
                nb_ok   = (r_y != '0);
                nb_addr = r_p - P_W'(i_cfg.size_x);
            end
            NB_YP: begin
                nb_ok   = !last_y;
                nb_addr = r_p + P_W'(i_cfg.size_x);
            end
            NB_ZM: begin
                nb_ok   = (r_z != '0);
                nb_addr = r_p - P_W'(r_incz);
            end
            NB_ZP: begin
                nb_ok   = !last_z;
                nb_addr = r_p + P_W'(r_incz);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
        nb_ok = nb_ok && (32'(nb_addr) < 32'(MAX_VOXELS));
    end

    // Divider operands: numerator 2|sum| + count over a divisor of 2*count,
    // which rounds the magnitude half up.
    always_comb begin
        for (int c = 0; c < LANES; c++) begin
            mag        = r_sum[c][SUM_W-1] ? SUM_W'(-r_sum[c]) : SUM_W'(r_sum[c]);
            div_num[c] = NUM_W'({mag, 1'b0}) + NUM_W'(r_cnt);
        end
    end

    assign pop_ok     = pop && !empty;
    assign empty      = (r_ocount == 2'd0);
    assign o_out_word = r_oq[r_orp];

    always_comb begin
        n_state    = r_state;
        n_x        = r_x;
        n_y        = r_y;
        n_z        = r_z;
        n_p        = r_p;
        n_incz     = r_incz;
        n_last     = r_last;
        n_front    = r_front;
        n_done     = r_done;
        n_k        = r_k;
        n_hit      = r_hit;
        n_nb       = r_nb;
        n_cnt      = r_cnt;
        n_sum      = r_sum;
        n_own      = r_own;
        n_rd_ok    = r_rd_ok;
        o_cmd_pop  = 1'b0;
        we         = 1'b0;
        waddr      = AW'(r_p);
        wdata      = r_own;
        mark_wdata = MARK_SUM - r_last;
        raddr      = AW'(r_p);
        div_start  = 1'b0;
        push_out   = 1'b0;
        out_word   = '0;
        vals       = '0;
        res        = '0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        KIND_LOAD: begin
                            o_cmd_pop = 1'b1;
                            n_front   = MARK_ONE;
                            if (i_cmd.in_range) begin
                                we         = 1'b1;
                                waddr      = AW'(i_cmd.voxel_index);
                                mark_wdata = i_cmd.in_stencil ? MARK_ONE : MARK_EMPTY;
                                for (int c = 0; c < LANES; c++) begin
                                    if (i_cmd.in_stencil && (LANES_W'(c) < i_cfg.lanes)
                                            && (c < IN_SAMPLES)) begin
                                        wdata[c*SB +: SB] = SB'(ld_ext[c*SAMPLE_W +: SAMPLE_W]);
                                    end else begin
                                        wdata[c*SB +: SB] = '0;
                                    end
                                end
                            end
                        end
                        KIND_READ: begin
                            if (r_ocount != 2'd2) begin
                                o_cmd_pop = 1'b1;
                                raddr     = AW'(i_cmd.voxel_index);
                                n_rd_ok   = i_cmd.in_range;
                                n_state   = S_RDW;
                            end
                        end
                        KIND_RUN: begin
                            o_cmd_pop = 1'b1;
                            n_last    = r_front;
                            n_done    = '0;
                            n_k       = '0;
                            n_incz    = 11'(i_cfg.size_x) * 11'(i_cfg.size_y);
                            n_state   = (i_cfg.pass_limit == '0) ? S_FIN : S_PASS;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_RDW: begin
                push_out = 1'b1;
                for (int c = 0; c < IN_SAMPLES; c++) begin
                    if (r_rd_ok && (c < LANES) && (LANES_W'(c) < i_cfg.lanes)) begin
                        vals[c] = SAMPLE_W'(rd_ext[c*SB +: SB]);
                    end
                end
                out_word.value_0 = vals[0];
                out_word.value_1 = vals[1];
                out_word.value_2 = vals[2];
                out_word.value_3 = vals[3];
                out_word.filled  = r_rd_ok && (mark_rdata != MARK_EMPTY);
                n_state          = S_IDLE;
            end
            S_PASS: begin
                n_hit   = 1'b0;
                n_x     = '0;
                n_y     = '0;
                n_z     = '0;
                n_p     = '0;
                n_state = S_VMARK;
            end
            S_VMARK: begin
                raddr   = AW'(r_p);
                n_state = (32'(r_p) < 32'(MAX_VOXELS)) ? S_VWAIT : S_NEXT;
            end
            S_VWAIT: begin
                n_own = rdata;
                if (mark_rdata != MARK_EMPTY) begin
                    n_state = S_NEXT;
                end else begin
                    n_nb    = NB_XM;
                    n_cnt   = '0;
                    for (int c = 0; c < LANES; c++) begin
                        n_sum[c] = '0;
                    end
                    n_state = S_NB;
                end
            end
            S_NB: begin
                if (r_nb == NB_END) begin
                    n_state = S_DIV;
                end else if (nb_ok) begin
                    raddr   = AW'(nb_addr);
                    n_state = S_NBW;
                end else begin
                    n_nb = r_nb + 3'd1;
                end
            end
            S_NBW: begin
                if (mark_rdata == r_last) begin
                    n_cnt = r_cnt + 3'd1;
                    for (int c = 0; c < LANES; c++) begin
                        if (LANES_W'(c) < i_cfg.lanes) begin
                            n_sum[c] = r_sum[c] + SUM_W'($signed(rdata[c*SB +: SB]));
                        end
                    end
                end
                n_nb    = r_nb + 3'd1;
                n_state = S_NB;
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_NEXT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIVW;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    we    = 1'b1;
                    waddr = AW'(r_p);
                    for (int c = 0; c < LANES; c++) begin
                        res = r_sum[c][SUM_W-1] ? NUM_W'(-div_quot[c]) : div_quot[c];
                        if (LANES_W'(c) < i_cfg.lanes) begin
                            wdata[c*SB +: SB] = SB'(res);
                        end
                    end
                    n_hit   = 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_p     = r_p + P_W'(1);
                n_state = S_VMARK;
                if (!last_x) begin
                    n_x = r_x + SIZE_W'(1);
                end else begin
                    n_x = '0;
                    if (!last_y) begin
                        n_y = r_y + SIZE_W'(1);
                    end else begin
                        n_y = '0;
                        if (!last_z) begin
                            n_z = r_z + SIZE_W'(1);
                        end else begin
                            if (!r_hit) begin
                                n_state = S_FIN;
                            end else begin
                                n_done = r_done + PASS_W'(1);
                                n_last = MARK_SUM - r_last;
                                n_k    = r_k + PASS_W'(1);
                                if (9'(r_k) + 9'd1 == 9'(i_cfg.pass_limit)) begin
                                    n_state = S_FIN;
                                end else begin
                                    n_state = S_PASS;
                                end
                            end
                        end
                    end
                end
            end
            S_FIN: begin
                if (r_ocount != 2'd2) begin
                    push_out             = 1'b1;
                    out_word.passes_done = r_done;
                    n_front              = r_last;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= MARK_ONE;
            r_owp    <= 1'b0;
            r_orp    <= 1'b0;
            r_ocount <= 2'd0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            if (push_out) begin
                r_owp <= !r_owp;
            end
            if (pop_ok) begin
                r_orp <= !r_orp;
            end
            r_ocount <= r_ocount + 2'(push_out) - 2'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_p     <= n_p;
        r_incz  <= n_incz;
        r_last  <= n_last;
        r_done  <= n_done;
        r_k     <= n_k;
        r_hit   <= n_hit;
        r_nb    <= n_nb;
        r_cnt   <= n_cnt;
        r_sum   <= n_sum;
        r_own   <= n_own;
        r_rd_ok <= n_rd_ok;
        if (push_out) begin
            r_oq[r_owp] <= out_word;
        end
    end

endmodule

// ===== rtl/masked_volume_spread_fill.sv =====
// ----------------------------------------------------------------------------
// masked_volume_spread_fill: masked volume six-neighbor spread fill
// Holds a voxel volume with fill marks and fills unmarked voxels by
// wavefront passes of rounded six-neighbor averages.
// ----------------------------------------------------------------------------
// Loads stream at one word per cycle while the back end is idle and are written to
// memory as it takes them. A read is popped only while the result queue has room and
// answers from the registered read data. A run pass walks the voxels in raster order,
// skips marked ones and, for an unmarked one, averages the neighbors inside the volume
// that carry the last front mark and writes the rounded mean. Reset is synchronous and
// clears control state only; memories are not cleared.
module masked_volume_spread_fill #(
    parameter int MAX_VOXELS  = 32768,
    parameter int LANES       = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Item queue side.
    input  logic                                 push,
    output logic                                 full,
    input  mvsf_pkg::t_in_word                   i_in_word,
    // Result queue side.
    output logic                                 empty,
    input  logic                                 pop,
    output mvsf_pkg::t_out_word                  o_out_word,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mvsf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mvsf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mvsf_pkg::*;

    // Configuration registers hold the raw written values; the sizes and the
    // component count are clamped to their legal ranges on the way to the back end.
    logic [SIZE_W-1:0]   r_size_x, r_size_y, r_size_z;
    logic [PASS_W-1:0]   r_pass_limit;
    logic [CCOUNT_W-1:0] r_comp_count;
    t_cfg                cfg;
    logic                cfg_we;

    logic   cmd_valid, cmd_pop;
    t_cmd   cmd;

    // The configuration port never stalls.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x     <= SIZE_W'(SIZE_MAX);
            r_size_y     <= SIZE_W'(SIZE_MAX);
            r_size_z     <= SIZE_W'(SIZE_MAX);
            r_pass_limit <= PASS_W'(1);
            r_comp_count <= CCOUNT_W'(1);
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_SIZE_X:     r_size_x     <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:     r_size_y     <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:     r_size_z     <= i_cfg_data[SIZE_W-1:0];
                CFG_PASS_LIMIT: r_pass_limit <= i_cfg_data[PASS_W-1:0];
                CFG_COMP_COUNT: r_comp_count <= i_cfg_data[CCOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A component count of zero means one lane, and counts above the lane
    // count mean all lanes.
    always_comb begin
        cfg.size_x     = clamp_size(r_size_x);
        cfg.size_y     = clamp_size(r_size_y);
        cfg.size_z     = clamp_size(r_size_z);
        cfg.pass_limit = r_pass_limit;
        if (r_comp_count == '0) begin
            cfg.lanes = LANES_W'(1);
        end else if (LANES_W'(r_comp_count) > LANES_W'(LANES)) begin
            cfg.lanes = LANES_W'(LANES);
        end else begin
            cfg.lanes = LANES_W'(r_comp_count);
        end
    end

    // The front end takes words and queues commands, so the item side keeps accepting
    // while the back end is busy with a read or a run, until its two-entry queue is full.
    mvsf_front #(.MAX_VOXELS(MAX_VOXELS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (i_in_word),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // The back end owns the voxel and mark memories, the pass sequencer, the
    // averaging divider and the result queue.
    mvsf_back #(
        .MAX_VOXELS  (MAX_VOXELS),
        .LANES       (LANES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== dv/masked_volume_spread_fill_test.sv =====
// ----------------------------------------------------------------------------
// masked_volume_spread_fill_test: self-checking bench for the spread fill
// Loads small volumes under many register settings, runs spreading passes
// and reads voxels back, predicting every result word with an internal model
// of the fill and comparing it field by field against the block's output.
// ----------------------------------------------------------------------------
module masked_volume_spread_fill_test;
    import mvsf_pkg::*;

    localparam int DEPTH       = 32768;
    localparam int NUM_LANES   = 4;
    localparam int CYCLE_LIMIT = 50000000;
    localparam int ITEM_TARGET = 1300;

    // The predictor keeps its own copy of the volume, the marks, the front
    // and the registers, and queues the result word each item should give.
    class volume_fill_predictor;
        int                 voxels [DEPTH][NUM_LANES];
        bit [MARK_W-1:0]    marks [DEPTH];
        bit [MARK_W-1:0]    front;
        int                 dim_x, dim_y, dim_z, pass_cap, comp_count;
        t_out_word          expected_words [$];
        int                 mismatches;
        int                 checked;

        function new();
            front      = MARK_ONE;
            dim_x      = 32;
            dim_y      = 32;
            dim_z      = 32;
            pass_cap   = 1;
            comp_count = 1;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SIZE_X:     dim_x = data[SIZE_W-1:0];
                CFG_SIZE_Y:     dim_y = data[SIZE_W-1:0];
                CFG_SIZE_Z:     dim_z = data[SIZE_W-1:0];
                CFG_PASS_LIMIT: pass_cap = data[PASS_W-1:0];
                CFG_COMP_COUNT: comp_count = data[CCOUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int lanes_in_use();
            if (comp_count < 1) return 1;
            if (comp_count > NUM_LANES) return NUM_LANES;
            return comp_count;
        endfunction

        function int fit_size(int v);
            if (v < 1) return 1;
            if (v > SIZE_MAX) return SIZE_MAX;
            return v;
        endfunction

        // Rounded average, halves going away from zero.
        function int rounded_mean(longint sum, longint cnt);
            longint mag;
            longint q;
            mag = (sum < 0) ? -sum : sum;
            q = (2 * mag + cnt) / (2 * cnt);
            return int'((sum < 0) ? -q : q);
        endfunction

        // One wavefront pass in raster order; returns 1 when anything filled.
        function bit sweep_once(bit [MARK_W-1:0] last, bit [MARK_W-1:0] nxt, int lanes);
            int     sx, sy, sz, p, q, k, c, nn;
            int     nb [6];
            longint sum [NUM_LANES];
            longint cnt;
            bit     hit;
            sx = fit_size(dim_x);
            sy = fit_size(dim_y);
            sz = fit_size(dim_z);
            hit = 0;
            for (int z = 0; z < sz; z++) begin
                for (int y = 0; y < sy; y++) begin
                    for (int x = 0; x < sx; x++) begin
                        p = x + y * sx + z * sx * sy;
                        if (p >= DEPTH || marks[p] != MARK_EMPTY) continue;
                        nn = 0;
                        if (x > 0)      begin nb[nn] = p - 1;       nn++; end
                        if (x + 1 < sx) begin nb[nn] = p + 1;       nn++; end
                        if (y > 0)      begin nb[nn] = p - sx;      nn++; end
                        if (y + 1 < sy) begin nb[nn] = p + sx;      nn++; end
                        if (z > 0)      begin nb[nn] = p - sx * sy; nn++; end
                        if (z + 1 < sz) begin nb[nn] = p + sx * sy; nn++; end
                        for (c = 0; c < NUM_LANES; c++) sum[c] = 0;
                        cnt = 0;
                        for (k = 0; k < nn; k++) begin
                            q = nb[k];
                            if (q >= DEPTH || marks[q] != last) continue;
                            cnt++;
                            for (c = 0; c < lanes; c++) sum[c] += voxels[q][c];
                        end
                        if (cnt > 0) begin
                            hit = 1;
                            marks[p] = nxt;
                            for (c = 0; c < lanes; c++) voxels[p][c] = rounded_mean(sum[c], cnt);
                        end
                    end
                end
            end
            return hit;
        endfunction

        // Notes one accepted word and queues the result it should produce.
        function void note_item(t_in_word w);
            int              lanes;
            int              samples [NUM_LANES];
            int              done;
            bit [MARK_W-1:0] last;
            t_out_word       r;
            lanes = lanes_in_use();
            samples[0] = w.sample_0;
            samples[1] = w.sample_1;
            samples[2] = w.sample_2;
            samples[3] = w.sample_3;
            r = '0;
            case (w.kind)
                KIND_LOAD: begin
                    front = MARK_ONE;
                    marks[w.voxel_index] = w.inside_req ? MARK_ONE : MARK_EMPTY;
                    for (int c = 0; c < NUM_LANES; c++)
                        voxels[w.voxel_index][c] = (w.inside_req && c < lanes) ? samples[c] : 0;
                end
                KIND_RUN: begin
                    done = 0;
                    last = front;
                    for (int k = 0; k < pass_cap; k++) begin
                        if (!sweep_once(last, MARK_SUM - last, lanes)) break;
                        done++;
                        last = MARK_SUM - last;
                    end
                    front = last;
                    r.passes_done = PASS_W'(done);
                    expected_words.push_back(r);
                end
                KIND_READ: begin
                    if (lanes > 0) r.value_0 = SAMPLE_W'(voxels[w.voxel_index][0]);
                    if (lanes > 1) r.value_1 = SAMPLE_W'(voxels[w.voxel_index][1]);
                    if (lanes > 2) r.value_2 = SAMPLE_W'(voxels[w.voxel_index][2]);
                    if (lanes > 3) r.value_3 = SAMPLE_W'(voxels[w.voxel_index][3]);
                    r.filled = (marks[w.voxel_index] != MARK_EMPTY);
                    expected_words.push_back(r);
                end
                default: ;
            endcase
        endfunction

        // Compares one popped word with the oldest expectation.
        function void check_word(t_out_word got);
            t_out_word exp_w;
            checked++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            exp_w = expected_words.pop_front();
            if (got.value_0 !== exp_w.value_0 || got.value_1 !== exp_w.value_1 ||
                got.value_2 !== exp_w.value_2 || got.value_3 !== exp_w.value_3 ||
                got.filled !== exp_w.filled || got.passes_done !== exp_w.passes_done) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected v=%0d %0d %0d %0d f=%0d p=%0d, got v=%0d %0d %0d %0d f=%0d p=%0d",
                             exp_w.value_0, exp_w.value_1, exp_w.value_2, exp_w.value_3,
                             exp_w.filled, exp_w.passes_done,
                             got.value_0, got.value_1, got.value_2, got.value_3,
                             got.filled, got.passes_done);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_in_word              i_in_word;
    logic                  empty;
    logic                  pop;
    t_out_word             o_out_word;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    masked_volume_spread_fill uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (i_in_word),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    volume_fill_predictor fill_model = new();

    // Idle percentages of the two sides, and the long receiver hold-off.
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold_request;
    int items_sent;
    int runs_sent;
    int reads_sent;
    int phases_done;
    int written_list [$];
    bit written_map [DEPTH];

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_in_word = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a stuck run ends the run as a failure.
    initial begin
        for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("** masked_volume_spread_fill: FAILED **");
        $finish;
    end

    // Receiver: a word is taken at an edge where pop is high and empty is low.
    // Values read right after the edge are still the ones from before it.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) fill_model.check_word(o_out_word);
            if (recv_hold_request > 0) begin
                hold_left = recv_hold_request;
                recv_hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one word and waits until the block takes it. Push stays high
    // unless the sender decides to idle after this word.
    task automatic send_word(t_in_word w);
        push <= 1'b1;
        i_in_word <= w;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        fill_model.note_item(w);
        items_sent++;
        if (w.kind == KIND_RUN) runs_sent++;
        if (w.kind == KIND_READ) reads_sent++;
        if (w.kind == KIND_LOAD && !written_map[w.voxel_index]) begin
            written_map[w.voxel_index] = 1;
            written_list.push_back(w.voxel_index);
        end
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        fill_model.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    // Lowers push and waits until every expected word has come back, then
    // lets a trailing load or ignored word drain out of the back end.
    task automatic drain();
        push <= 1'b0;
        while (fill_model.expected_words.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    function automatic t_in_word make_word(logic [KIND_W-1:0] kind, int idx, bit in_stencil);
        t_in_word w;
        w.kind = kind;
        w.voxel_index = IDX_W'(idx);
        w.inside_req = in_stencil;
        w.sample_0 = SAMPLE_W'($urandom);
        w.sample_1 = SAMPLE_W'($urandom);
        w.sample_2 = SAMPLE_W'($urandom);
        w.sample_3 = SAMPLE_W'($urandom);
        return w;
    endfunction

    function automatic int pick_written();
        return written_list[$urandom_range(written_list.size() - 1)];
    endfunction

    // Picks a size register value: mostly tiny, sometimes zero or above range.
    function automatic int pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 0;
        if (r < 14) return 63;
        return $urandom_range(1, 4);
    endfunction

    task automatic random_phase();
        int sx, sy, sz, vol, inside_pct, r, shape, lim;
        t_in_word w;
        shape = $urandom_range(9);
        if (shape == 0) begin
            // Long thin volumes reach the size extremes on one axis.
            sx = 1;
            sy = 1;
            sz = 1;
            case ($urandom_range(3))
                0: sx = 32;
                1: sy = 32;
                2: sz = 32;
                default: sx = 63;
            endcase
        end else begin
            sx = pick_size();
            sy = pick_size();
            sz = pick_size();
            if (sx == 63) sx = $urandom_range(0, 1) ? 63 : 3;
            if (fill_model.fit_size(sx) * fill_model.fit_size(sy)
                    * fill_model.fit_size(sz) > 200) begin
                sy = 1;
                sz = 1;
            end
        end
        r = $urandom_range(9);
        lim = (r < 2) ? 0 : (r < 4) ? 255 : (r < 6) ? 1 : $urandom_range(2, 254);
        write_reg(CFG_SIZE_X, CFG_DATA_W'(sx));
        write_reg(CFG_SIZE_Y, CFG_DATA_W'(sy));
        write_reg(CFG_SIZE_Z, CFG_DATA_W'(sz));
        write_reg(CFG_PASS_LIMIT, CFG_DATA_W'(lim));
        write_reg(CFG_COMP_COUNT, CFG_DATA_W'($urandom_range(0, 7)));
        vol = fill_model.fit_size(sx) * fill_model.fit_size(sy) * fill_model.fit_size(sz);
        inside_pct = $urandom_range(3, 60);
        // Every voxel of the volume is loaded before anything can run.
        for (int p = 0; p < vol; p++)
            send_word(make_word(KIND_LOAD, p, $urandom_range(99) < inside_pct));
        send_word(make_word(KIND_RUN, 0, 0));
        for (int n = 0; n < 40; n++) begin
            r = $urandom_range(99);
            if (r < 45)
                w = make_word(KIND_READ, pick_written(), $urandom_range(1));
            else if (r < 62)
                w = make_word(KIND_LOAD, $urandom_range(vol - 1),
                              $urandom_range(99) < inside_pct);
            else if (r < 80)
                w = make_word(KIND_RUN, $urandom_range(DEPTH - 1), $urandom_range(1));
            else if (r < 93)
                w = make_word(KIND_LOAD, $urandom_range(DEPTH - 1), $urandom_range(1));
            else
                w = make_word(KIND_SPARE, $urandom_range(DEPTH - 1), $urandom_range(1));
            send_word(w);
        end
        drain();
        phases_done++;
    endtask

    initial begin : stimulus
        t_in_word w;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_request = 0;
        items_sent = 0;
        runs_sent = 0;
        reads_sent = 0;
        phases_done = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: a 2x2x2 cube with two inside corners holding the
        // sample extremes, a full run, a read of every voxel, the top address,
        // an ignored kind, and a second run that finds nothing left to fill.
        write_reg(CFG_SIZE_X, 2);
        write_reg(CFG_SIZE_Y, 2);
        write_reg(CFG_SIZE_Z, 2);
        write_reg(CFG_PASS_LIMIT, 255);
        write_reg(CFG_COMP_COUNT, 4);
        for (int p = 0; p < 8; p++) begin
            w = make_word(KIND_LOAD, p, (p == 0 || p == 7));
            if (p == 0) begin
                w.sample_0 = 16'sh7fff;
                w.sample_1 = -16'sh8000;
                w.sample_2 = 16'sd1;
                w.sample_3 = -16'sd1;
            end else if (p == 7) begin
                w.sample_0 = -16'sh8000;
                w.sample_1 = 16'sh7fff;
                w.sample_2 = -16'sd3;
                w.sample_3 = 16'sd0;
            end
            send_word(w);
        end
        send_word(make_word(KIND_RUN, 0, 0));
        for (int p = 0; p < 8; p++) send_word(make_word(KIND_READ, p, 0));
        w = make_word(KIND_LOAD, DEPTH - 1, 1);
        w.sample_0 = -16'sh8000;
        w.sample_3 = 16'sh7fff;
        send_word(w);
        send_word(make_word(KIND_READ, DEPTH - 1, 1));
        send_word(make_word(KIND_SPARE, DEPTH - 1, 1));
        send_word(make_word(KIND_RUN, 0, 1));
        // The sender pauses here until every word has come back.
        drain();

        // Long receiver hold-off while reads keep coming, so the block fills up.
        recv_hold_request = 400;
        for (int n = 0; n < 80; n++) send_word(make_word(KIND_READ, pick_written(), 0));
        drain();

        // Random part, in three stretches of idling.
        send_idle_pct = 28;
        recv_idle_pct = 79;
        while (items_sent < ITEM_TARGET / 3) random_phase();
        send_idle_pct = 79;
        recv_idle_pct = 28;
        while (items_sent < 2 * ITEM_TARGET / 3) random_phase();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (items_sent < ITEM_TARGET) random_phase();

        drain();
        $display("covered %0d words (%0d runs, %0d reads) over %0d register settings",
                 items_sent, runs_sent, reads_sent, phases_done + 1);
        $display("%0d result words checked, %0d mismatches",
                 fill_model.checked, fill_model.mismatches);
        if (fill_model.mismatches == 0 && fill_model.expected_words.size() == 0)
            $display("** masked_volume_spread_fill: PASSED **");
        else
            $display("** masked_volume_spread_fill: FAILED **");
        $finish;
    end

endmodule
